// ===== hdl/mfi_pkg.sv =====
`default_nettype none
package mfi_pkg;

    localparam int OUT_POINTS_DEF = 101;
    localparam int Q15_W          = 16;
    localparam int CEN_W          = 15;

    localparam logic [Q15_W-1:0] ONE_Q15 = 16'd32768;

    localparam logic [1:0] CLS_SHORT  = 2'd0;
    localparam logic [1:0] CLS_MEDIUM = 2'd1;
    localparam logic [1:0] CLS_LONG   = 2'd2;

    typedef logic [Q15_W-1:0] t_q15;
    typedef t_q15 [2:0]       t_q15_x3;

    typedef struct packed {
        logic             empty;
        logic [CEN_W-1:0] centroid;
        logic [1:0]       winner;
    } t_dfz_res;

    // floor(32768 * n / 10)
    function automatic t_q15 ramp10(input logic [3:0] n);
        t_q15 v;
        case (n)
            4'd0:    v = 16'd0;
            4'd1:    v = 16'd3276;
            4'd2:    v = 16'd6553;
            4'd3:    v = 16'd9830;
            4'd4:    v = 16'd13107;
            4'd5:    v = 16'd16384;
            4'd6:    v = 16'd19660;
            4'd7:    v = 16'd22937;
            4'd8:    v = 16'd26214;
            4'd9:    v = 16'd29491;
            4'd10:   v = ONE_Q15;
            default: v = ONE_Q15;
        endcase
        return v;
    endfunction

    // floor(32768 * n / 25)
    function automatic t_q15 ramp25(input logic [4:0] n);
        t_q15 v;
        case (n)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd1310;
            5'd2:    v = 16'd2621;
            5'd3:    v = 16'd3932;
            5'd4:    v = 16'd5242;
            5'd5:    v = 16'd6553;
            5'd6:    v = 16'd7864;
            5'd7:    v = 16'd9175;
            5'd8:    v = 16'd10485;
            5'd9:    v = 16'd11796;
            5'd10:   v = 16'd13107;
            5'd11:   v = 16'd14417;
            5'd12:   v = 16'd15728;
            5'd13:   v = 16'd17039;
            5'd14:   v = 16'd18350;
            5'd15:   v = 16'd19660;
            5'd16:   v = 16'd20971;
            5'd17:   v = 16'd22282;
            5'd18:   v = 16'd23592;
            5'd19:   v = 16'd24903;
            5'd20:   v = 16'd26214;
            5'd21:   v = 16'd27525;
            5'd22:   v = 16'd28835;
            5'd23:   v = 16'd30146;
            5'd24:   v = 16'd31457;
            5'd25:   v = ONE_Q15;
            default: v = ONE_Q15;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/mfi_fuzz.sv =====
`default_nettype none
module mfi_fuzz (
    input  logic [6:0]       i_temperature,
    input  logic [6:0]       i_volume,
    output mfi_pkg::t_q15_x3 o_temp_deg,
    output mfi_pkg::t_q15_x3 o_vol_deg,
    output mfi_pkg::t_q15_x3 o_strength
);

    function automatic mfi_pkg::t_q15 up(input logic [6:0] x, input logic [6:0] a);
        logic [6:0] d;
        d = x - a;
        return mfi_pkg::ramp10(d[3:0]);
    endfunction

    function automatic mfi_pkg::t_q15 down(input logic [6:0] x, input logic [6:0] c);
        logic [6:0] d;
        d = c - x;
        return mfi_pkg::ramp10(d[3:0]);
    endfunction

    mfi_pkg::t_q15 tmax;

    always_comb begin
        o_temp_deg[0] = (i_temperature <= 7'd10) ? mfi_pkg::ONE_Q15 :
                        (i_temperature <= 7'd20) ? down(i_temperature, 7'd20) : '0;
        o_temp_deg[1] = (i_temperature < 7'd10)  ? '0 :
                        (i_temperature < 7'd20)  ? up(i_temperature, 7'd10) :
                        (i_temperature <= 7'd40) ? mfi_pkg::ONE_Q15 :
                        (i_temperature <= 7'd50) ? down(i_temperature, 7'd50) : '0;
        // open right shoulder
        o_temp_deg[2] = (i_temperature < 7'd40)  ? '0 :
                        (i_temperature < 7'd50)  ? up(i_temperature, 7'd40) :
                        mfi_pkg::ONE_Q15;

        o_vol_deg[0] = (i_volume <= 7'd30) ? mfi_pkg::ONE_Q15 :
                       (i_volume <= 7'd40) ? down(i_volume, 7'd40) : '0;
        o_vol_deg[1] = (i_volume < 7'd30)  ? '0 :
                       (i_volume < 7'd40)  ? up(i_volume, 7'd30) :
                       (i_volume <= 7'd50) ? mfi_pkg::ONE_Q15 :
                       (i_volume <= 7'd60) ? down(i_volume, 7'd60) : '0;
        o_vol_deg[2] = (i_volume < 7'd50)  ? '0 :
                       (i_volume < 7'd60)  ? up(i_volume, 7'd50) :
                       mfi_pkg::ONE_Q15;

        // max over temperature sets of min(t, v) equals min(max t, v)
        tmax = o_temp_deg[0];
        if (o_temp_deg[1] > tmax) begin
            tmax = o_temp_deg[1];
        end
        if (o_temp_deg[2] > tmax) begin
            tmax = o_temp_deg[2];
        end
        for (int k = 0; k < 3; k++) begin
            o_strength[k] = (tmax < o_vol_deg[k]) ? tmax : o_vol_deg[k];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mfi_defuzz.sv =====
`default_nettype none
module mfi_defuzz #(
    parameter int OUT_POINTS = mfi_pkg::OUT_POINTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_ack,
    input  mfi_pkg::t_q15_x3  i_strength,
    output logic              o_done,
    output mfi_pkg::t_dfz_res o_res
);

    localparam int CEN_W    = mfi_pkg::CEN_W;
    localparam int Q15_W    = mfi_pkg::Q15_W;
    localparam int DEN      = OUT_POINTS - 1;
    localparam int D10      = 10 * DEN;
    localparam int D25      = 25 * DEN;
    localparam int STEP     = 32768 * 100;
    localparam int Q10_STEP = STEP / D10;
    localparam int R10_STEP = STEP % D10;
    localparam int Q25_STEP = STEP / D25;
    localparam int R25_STEP = STEP % D25;
    localparam int Q_W      = 20;
    localparam int R_W      = $clog2(2 * D25 + 1);
    localparam int I_W      = $clog2(OUT_POINTS + 1);
    localparam int P_W      = $clog2(100 * DEN + 1);
    localparam int DEN_W    = $clog2(DEN + 1);
    localparam int AREA_W   = $clog2(32768 * OUT_POINTS + 1);
    localparam longint NUM_MAX = longint'(32768) * longint'(100 * DEN) * longint'(OUT_POINTS);
    localparam int NUM_W    = $clog2(NUM_MAX + 1);
    localparam int VD_W     = AREA_W + DEN_W;
    localparam int CMP_W    = (NUM_W + 8 > VD_W + CEN_W) ? NUM_W + 8 : VD_W + CEN_W;
    localparam int CNT_W    = $clog2(CEN_W);
    localparam int CEN_MAX  = 25600;
    // quotients of 32768 * (p - 55 den) / (10 den) and 32768 * (p - 25 den) / (25 den) at p = 0
    localparam int Q10_INIT  = -180224;
    localparam int Q25_INIT  = -32768;
    localparam int SHORT_OFS = -32768;
    localparam int MED_OFS   = 65536;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WALK  = 7'b0000010,
        S_FLUSH = 7'b0000100,
        S_SCALE = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_WIN   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    function automatic mfi_pkg::t_q15 clamp(input logic signed [Q_W-1:0] v);
        if (v <= 0) begin
            return '0;
        end
        if (v >= 32768) begin
            return mfi_pkg::ONE_Q15;
        end
        return v[Q15_W-1:0];
    endfunction

    function automatic mfi_pkg::t_q15 min2(input mfi_pkg::t_q15 a, input mfi_pkg::t_q15 b);
        return (a < b) ? a : b;
    endfunction

    t_state                   r_state;
    logic [I_W-1:0]           r_i;
    logic [P_W-1:0]           r_p;
    logic signed [Q_W-1:0]    r_q10;
    logic signed [Q_W-1:0]    r_q25;
    logic [R_W-1:0]           r_r10;
    logic [R_W-1:0]           r_r25;
    mfi_pkg::t_q15            r_b;
    logic [P_W-1:0]           r_bp;
    logic                     r_bv;
    logic [NUM_W-1:0]         r_num;
    logic [AREA_W-1:0]        r_area;
    logic [CMP_W-1:0]         r_rem;
    logic [CMP_W-1:0]         r_sd;
    logic [CEN_W-1:0]         r_quo;
    logic [CNT_W-1:0]         r_cnt;
    mfi_pkg::t_dfz_res        r_res;

    logic [R_W-1:0]           r10_sum;
    logic [R_W-1:0]           r25_sum;
    logic                     c10;
    logic                     c25;
    logic [R_W-1:0]           n_r10;
    logic [R_W-1:0]           n_r25;
    logic signed [Q_W-1:0]    n_q10;
    logic signed [Q_W-1:0]    n_q25;
    logic signed [Q_W-1:0]    short_raw;
    logic signed [Q_W-1:0]    med_raw;
    mfi_pkg::t_q15            m_short;
    mfi_pkg::t_q15            m_med;
    mfi_pkg::t_q15            m_long;
    mfi_pkg::t_q15            c0;
    mfi_pkg::t_q15            c1;
    mfi_pkg::t_q15            c2;
    mfi_pkg::t_q15            n_b;
    logic                     last;
    logic [Q15_W+P_W-1:0]     prod;
    logic [VD_W-1:0]          vd;
    logic                     ge;
    logic [CEN_W-1:0]         cen;
    logic [6:0]               x;
    logic [6:0]               x_off;
    mfi_pkg::t_q15            w0;
    mfi_pkg::t_q15            w1;
    mfi_pkg::t_q15            w2;
    logic [1:0]               win;

    // sampled output sets, quotients tracked incrementally per point
    always_comb begin
        r10_sum = r_r10 + R_W'(R10_STEP);
        c10     = (r10_sum >= R_W'(D10));
        n_r10   = c10 ? r10_sum - R_W'(D10) : r10_sum;
        n_q10   = r_q10 + Q_W'(Q10_STEP) + Q_W'(c10);
        r25_sum = r_r25 + R_W'(R25_STEP);
        c25     = (r25_sum >= R_W'(D25));
        n_r25   = c25 ? r25_sum - R_W'(D25) : r25_sum;
        n_q25   = r_q25 + Q_W'(Q25_STEP) + Q_W'(c25);

        // falling ramps are the mirrored ceiling of the rising ones
        short_raw = Q_W'(SHORT_OFS) - r_q10 - Q_W'(|r_r10);
        med_raw   = Q_W'(MED_OFS) - r_q25 - Q_W'(|r_r25);
        m_long    = clamp(r_q10);
        m_short   = clamp(short_raw);
        m_med     = min2(clamp(r_q25), clamp(med_raw));

        c0  = min2(m_short, i_strength[0]);
        c1  = min2(m_med, i_strength[1]);
        c2  = min2(m_long, i_strength[2]);
        n_b = c0;
        if (c1 > n_b) begin
            n_b = c1;
        end
        if (c2 > n_b) begin
            n_b = c2;
        end

        last = (r_i == I_W'(OUT_POINTS - 1));
        prod = (Q15_W + P_W)'(r_b) * (Q15_W + P_W)'(r_bp);
        vd   = VD_W'(r_area) * VD_W'(DEN);
        ge   = (r_rem >= r_sd);
    end

    // class with the highest membership at the whole centroid position
    always_comb begin
        cen   = (r_quo > CEN_W'(CEN_MAX)) ? CEN_W'(CEN_MAX) : r_quo;
        x     = cen[CEN_W-1:8];
        x_off = (x >= 7'd50) ? x - 7'd50 : 7'd50 - x;
        w0    = (x <= 7'd35) ? mfi_pkg::ONE_Q15 :
                (x >= 7'd45) ? '0 : mfi_pkg::ramp10(4'(7'd45 - x));
        w1    = (x_off >= 7'd25) ? '0 : mfi_pkg::ramp25(5'(7'd25 - x_off));
        w2    = (x >= 7'd65) ? mfi_pkg::ONE_Q15 :
                (x <= 7'd55) ? '0 : mfi_pkg::ramp10(4'(x - 7'd55));
        if (w2 >= w1 && w2 >= w0) begin
            win = mfi_pkg::CLS_LONG;
        end else if (w1 >= w0) begin
            win = mfi_pkg::CLS_MEDIUM;
        end else begin
            win = mfi_pkg::CLS_SHORT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bv    <= 1'b0;
        end else begin
            r_bv <= (r_state == S_WALK);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (last) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: r_state <= S_SCALE;
                S_SCALE: r_state <= S_DIV;
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_WIN;
                    end
                end
                S_WIN: r_state <= S_DONE;
                S_DONE: begin
                    if (i_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_bv) begin
            r_num  <= r_num + NUM_W'(prod);
            r_area <= r_area + AREA_W'(r_b);
        end
        case (r_state)
            S_IDLE: begin
                r_i    <= '0;
                r_p    <= '0;
                r_q10  <= Q_W'(Q10_INIT);
                r_q25  <= Q_W'(Q25_INIT);
                r_r10  <= '0;
                r_r25  <= '0;
                r_num  <= '0;
                r_area <= '0;
            end
            S_WALK: begin
                r_b   <= n_b;
                r_bp  <= r_p;
                r_i   <= r_i + 1'b1;
                r_p   <= r_p + P_W'(100);
                r_q10 <= n_q10;
                r_r10 <= n_r10;
                r_q25 <= n_q25;
                r_r25 <= n_r25;
            end
            S_SCALE: begin
                r_rem <= CMP_W'({r_num, 8'h00});
                r_sd  <= CMP_W'(vd) << (CEN_W - 1);
                r_quo <= '0;
                r_cnt <= CNT_W'(CEN_W - 1);
            end
            S_DIV: begin
                if (ge) begin
                    r_rem <= r_rem - r_sd;
                end
                r_sd  <= r_sd >> 1;
                r_quo <= {r_quo[CEN_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
            end
            S_WIN: begin
                if (r_area == '0) begin
                    r_res.empty    <= 1'b1;
                    r_res.centroid <= '0;
                    r_res.winner   <= mfi_pkg::CLS_SHORT;
                end else begin
                    r_res.empty    <= 1'b0;
                    r_res.centroid <= cen;
                    r_res.winner   <= win;
                end
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

endmodule
`default_nettype wire

// ===== hdl/mamdani_fuzzy_inference_two_input.sv =====
`default_nettype none
// channel  direction  handshake                 payload
// request  in         i_in_valid / o_in_ready   i_temperature, i_volume
// result   out        o_out_valid / i_out_ready degrees, strengths, centroid, class, empty flag
//
// after acceptance a request runs through the defuzzifier walk, one output
// sample per cycle, then the flush, scale, restoring divider and winner
// steps, and its result moves into the output register once that can take it.
// no new request is taken while one is in work; a finished result waits in
// the output register and the next request may run behind it.
// reset is synchronous, active low, and clears the handshake and sequencer state only.
module mamdani_fuzzy_inference_two_input #(
    parameter int OUT_POINTS = mfi_pkg::OUT_POINTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [6:0]                i_temperature,
    input  logic [6:0]                i_volume,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [15:0]               o_temp_low_degree,
    output logic [15:0]               o_temp_mid_degree,
    output logic [15:0]               o_temp_high_degree,
    output logic [15:0]               o_vol_low_degree,
    output logic [15:0]               o_vol_mid_degree,
    output logic [15:0]               o_vol_high_degree,
    output logic [15:0]               o_short_strength,
    output logic [15:0]               o_medium_strength,
    output logic [15:0]               o_long_strength,
    output logic [mfi_pkg::CEN_W-1:0] o_centroid,
    output logic [1:0]                o_winner_class,
    output logic                      o_empty_area
);

    mfi_pkg::t_q15_x3  fz_td;
    mfi_pkg::t_q15_x3  fz_vd;
    mfi_pkg::t_q15_x3  fz_s;
    mfi_pkg::t_dfz_res dfz_res;
    logic              dfz_done;

    logic              r_busy;
    logic              r_start;
    logic              r_out_valid;
    mfi_pkg::t_q15_x3  r_td;
    mfi_pkg::t_q15_x3  r_vd;
    mfi_pkg::t_q15_x3  r_s;
    mfi_pkg::t_q15_x3  r_o_td;
    mfi_pkg::t_q15_x3  r_o_vd;
    mfi_pkg::t_q15_x3  r_o_s;
    mfi_pkg::t_dfz_res r_o_res;

    logic              accept;
    logic              ack;

    mfi_fuzz u_fuzz (
        .i_temperature (i_temperature),
        .i_volume      (i_volume),
        .o_temp_deg    (fz_td),
        .o_vol_deg     (fz_vd),
        .o_strength    (fz_s)
    );

    mfi_defuzz #(
        .OUT_POINTS (OUT_POINTS)
    ) u_defuzz (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_ack      (ack),
        .i_strength (r_s),
        .o_done     (dfz_done),
        .o_res      (dfz_res)
    );

    assign accept = i_in_valid && !r_busy;
    assign ack    = dfz_done && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= accept;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (ack) begin
                r_busy <= 1'b0;
            end
            if (ack) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_td <= fz_td;
            r_vd <= fz_vd;
            r_s  <= fz_s;
        end
        if (ack) begin
            r_o_td  <= r_td;
            r_o_vd  <= r_vd;
            r_o_s   <= r_s;
            r_o_res <= dfz_res;
        end
    end

    assign o_in_ready         = !r_busy;
    assign o_out_valid        = r_out_valid;
    assign o_temp_low_degree  = r_o_td[0];
    assign o_temp_mid_degree  = r_o_td[1];
    assign o_temp_high_degree = r_o_td[2];
    assign o_vol_low_degree   = r_o_vd[0];
    assign o_vol_mid_degree   = r_o_vd[1];
    assign o_vol_high_degree  = r_o_vd[2];
    assign o_short_strength   = r_o_s[0];
    assign o_medium_strength  = r_o_s[1];
    assign o_long_strength    = r_o_s[2];
    assign o_centroid         = r_o_res.centroid;
    assign o_winner_class     = r_o_res.winner;
    assign o_empty_area       = r_o_res.empty;

endmodule
`default_nettype wire

// ===== tb/mamdani_fuzzy_inference_two_input_tb.sv =====
`timescale 1ns / 100ps
module mamdani_fuzzy_inference_two_input_tb;

    localparam longint ONE        = 32768;
    localparam int     NUM_PHASES = 4;
    localparam int     RAND_PER_PHASE = 400;
    localparam int     MAX_PRINTS = 40;
    localparam int     DRAIN_CYCLES = 2 * (mfi_pkg::OUT_POINTS_DEF + 22);

    // idle percentages per phase: none, sender, receiver, both
    localparam int SEND_IDLE [NUM_PHASES] = '{0, 86, 0, 29};
    localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 86, 29};

    typedef struct {
        logic [6:0] temperature;
        logic [6:0] volume;
        int         phase;
    } t_request;

    typedef struct {
        logic [6:0]                temperature;
        logic [6:0]                volume;
        mfi_pkg::t_q15_x3          temp_deg;
        mfi_pkg::t_q15_x3          vol_deg;
        mfi_pkg::t_q15_x3          strength;
        logic [mfi_pkg::CEN_W-1:0] centroid;
        logic [1:0]                winner;
        logic                      empty;
    } t_fuzzy_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [6:0]                i_temperature;
    logic [6:0]                i_volume;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [15:0]               o_temp_low_degree;
    logic [15:0]               o_temp_mid_degree;
    logic [15:0]               o_temp_high_degree;
    logic [15:0]               o_vol_low_degree;
    logic [15:0]               o_vol_mid_degree;
    logic [15:0]               o_vol_high_degree;
    logic [15:0]               o_short_strength;
    logic [15:0]               o_medium_strength;
    logic [15:0]               o_long_strength;
    logic [mfi_pkg::CEN_W-1:0] o_centroid;
    logic [1:0]                o_winner_class;
    logic                      o_empty_area;

    t_request      pending_requests[$];
    t_fuzzy_result expected_results[$];
    int            cur_phase;
    int            mismatch_count;

    mamdani_fuzzy_inference_two_input dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_temperature      (i_temperature),
        .i_volume           (i_volume),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_temp_low_degree  (o_temp_low_degree),
        .o_temp_mid_degree  (o_temp_mid_degree),
        .o_temp_high_degree (o_temp_high_degree),
        .o_vol_low_degree   (o_vol_low_degree),
        .o_vol_mid_degree   (o_vol_mid_degree),
        .o_vol_high_degree  (o_vol_high_degree),
        .o_short_strength   (o_short_strength),
        .o_medium_strength  (o_medium_strength),
        .o_long_strength    (o_long_strength),
        .o_centroid         (o_centroid),
        .o_winner_class     (o_winner_class),
        .o_empty_area       (o_empty_area)
    );

    function automatic longint q15_ramp(longint num, longint den);
        if (num <= 0) return 0;
        if (num >= den) return ONE;
        return (ONE * num) / den;
    endfunction

    function automatic longint trap_member(longint x, longint a, longint b, longint c,
                                           longint d, bit shoulder);
        if (x < a) return 0;
        if (x < b) return q15_ramp(x - a, b - a);
        if (shoulder) return ONE;
        if (x <= c) return ONE;
        if (x <= d) return q15_ramp(d - x, d - c);
        return 0;
    endfunction

    // output set membership at position p / den
    function automatic longint out_member(logic [1:0] cls, longint p, longint den);
        longint diff;
        case (cls)
            mfi_pkg::CLS_SHORT: begin
                if (p <= 35 * den) return ONE;
                return q15_ramp(45 * den - p, 10 * den);
            end
            mfi_pkg::CLS_MEDIUM: begin
                diff = p - 50 * den;
                if (diff < 0) diff = -diff;
                return q15_ramp(25 * den - diff, 25 * den);
            end
            default: begin
                if (p >= 65 * den) return ONE;
                return q15_ramp(p - 55 * den, 10 * den);
            end
        endcase
    endfunction

    function automatic t_fuzzy_result fuzzy_infer(logic [6:0] temp, logic [6:0] vol);
        t_fuzzy_result r;
        longint        td[3];
        longint        vd[3];
        longint        s[3];
        longint        den;
        longint        num;
        longint        area;
        longint        agg;
        longint        p;
        longint        cen;
        longint        best;
        longint        m;
        logic [1:0]    win;
        den  = (mfi_pkg::OUT_POINTS_DEF > 1) ? mfi_pkg::OUT_POINTS_DEF - 1 : 1;
        td[0] = trap_member(temp, 0, 0, 10, 20, 1'b0);
        td[1] = trap_member(temp, 10, 20, 40, 50, 1'b0);
        td[2] = trap_member(temp, 40, 50, 0, 0, 1'b1);
        vd[0] = trap_member(vol, 0, 0, 30, 40, 1'b0);
        vd[1] = trap_member(vol, 30, 40, 50, 60, 1'b0);
        vd[2] = trap_member(vol, 50, 60, 0, 0, 1'b1);
        for (int k = 0; k < 3; k++) begin
            s[k] = 0;
            for (int j = 0; j < 3; j++) begin
                m = (td[j] < vd[k]) ? td[j] : vd[k];
                if (m > s[k]) s[k] = m;
            end
        end
        num  = 0;
        area = 0;
        for (int i = 0; i < mfi_pkg::OUT_POINTS_DEF; i++) begin
            p   = 100 * i;
            agg = 0;
            for (int k = 0; k < 3; k++) begin
                m = out_member(k[1:0], p, den);
                if (s[k] < m) m = s[k];
                if (m > agg) agg = m;
            end
            num  += agg * p;
            area += agg;
        end
        r.temperature = temp;
        r.volume      = vol;
        r.centroid    = '0;
        r.winner      = mfi_pkg::CLS_SHORT;
        r.empty       = 1'b0;
        if (area == 0) begin
            r.empty = 1'b1;
        end else begin
            cen = (num * 256) / (area * den);
            if (cen > 25600) cen = 25600;
            best = -1;
            win  = mfi_pkg::CLS_SHORT;
            for (int k = 0; k < 3; k++) begin
                m = out_member(k[1:0], cen >>> 8, 1);
                if (m >= best) begin
                    best = m;
                    win  = k[1:0];
                end
            end
            r.centroid = cen[mfi_pkg::CEN_W-1:0];
            r.winner   = win;
        end
        for (int k = 0; k < 3; k++) begin
            r.temp_deg[k] = td[k][15:0];
            r.vol_deg[k]  = vd[k][15:0];
            r.strength[k] = s[k][15:0];
        end
        return r;
    endfunction

    task automatic compare_field(string name, longint got, longint want, t_fuzzy_result e);
        if (got != want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_PRINTS)
                $display("mismatch %s: got %0d want %0d (temperature %0d volume %0d)",
                         name, got, want, e.temperature, e.volume);
        end
    endtask

    function automatic logic [6:0] pick_value();
        if ($urandom_range(99) < 80) return 7'($urandom_range(100));
        return 7'($urandom_range(127));
    endfunction

    task automatic add_request(logic [6:0] temp, logic [6:0] vol, int phase);
        t_request req;
        req.temperature = temp;
        req.volume      = vol;
        req.phase       = phase;
        pending_requests = {pending_requests, req};
    endtask

    always #1 i_clk = ~i_clk;

    // driver
    always @(posedge i_clk) begin : driver_proc
        t_request req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_requests.size() != 0 &&
                $urandom_range(99) >= SEND_IDLE[pending_requests[0].phase]) begin
                req = pending_requests.pop_front();
                i_in_valid    <= 1'b1;
                i_temperature <= req.temperature;
                i_volume      <= req.volume;
                cur_phase     <= req.phase;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= RECV_STALL[cur_phase]);
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor_proc
        t_fuzzy_result e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_PRINTS)
                        $display("unexpected result: centroid %0d", o_centroid);
                end else begin
                    e = expected_results.pop_front();
                    compare_field("temp_low_degree", o_temp_low_degree, e.temp_deg[0], e);
                    compare_field("temp_mid_degree", o_temp_mid_degree, e.temp_deg[1], e);
                    compare_field("temp_high_degree", o_temp_high_degree, e.temp_deg[2], e);
                    compare_field("vol_low_degree", o_vol_low_degree, e.vol_deg[0], e);
                    compare_field("vol_mid_degree", o_vol_mid_degree, e.vol_deg[1], e);
                    compare_field("vol_high_degree", o_vol_high_degree, e.vol_deg[2], e);
                    compare_field("short_strength", o_short_strength, e.strength[0], e);
                    compare_field("medium_strength", o_medium_strength, e.strength[1], e);
                    compare_field("long_strength", o_long_strength, e.strength[2], e);
                    compare_field("centroid", o_centroid, e.centroid, e);
                    compare_field("winner_class", o_winner_class, e.winner, e);
                    compare_field("empty_area", o_empty_area, e.empty, e);
                end
            end
            if (i_in_valid && o_in_ready)
                expected_results = {expected_results, fuzzy_infer(i_temperature, i_volume)};
        end
    end

    initial begin
        #2000000;
        $display("mamdani_fuzzy_inference_two_input_tb failed");
        $finish;
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_temperature  = '0;
        i_volume       = '0;
        i_out_ready    = 1'b0;
        cur_phase      = 0;
        mismatch_count = 0;

        // corners, set breakpoints, out-of-range inputs, shoulders
        add_request(7'd0, 7'd0, 0);
        add_request(7'd100, 7'd100, 0);
        add_request(7'd127, 7'd127, 0);
        add_request(7'd0, 7'd127, 0);
        add_request(7'd127, 7'd0, 0);
        add_request(7'd10, 7'd30, 0);
        add_request(7'd20, 7'd40, 0);
        add_request(7'd40, 7'd50, 0);
        add_request(7'd50, 7'd60, 0);
        add_request(7'd15, 7'd35, 0);
        add_request(7'd45, 7'd55, 0);
        add_request(7'd60, 7'd80, 0);
        add_request(7'd100, 7'd0, 0);
        add_request(7'd0, 7'd100, 0);
        add_request(7'd30, 7'd45, 0);
        add_request(7'd25, 7'd65, 0);
        add_request(7'd5, 7'd101, 0);
        add_request(7'd101, 7'd20, 0);
        add_request(7'd35, 7'd55, 0);
        add_request(7'd12, 7'd38, 0);
        add_request(7'd64, 7'd64, 0);
        add_request(7'd1, 7'd1, 0);
        add_request(7'd99, 7'd99, 0);
        add_request(7'd50, 7'd50, 0);
        for (int ph = 0; ph < NUM_PHASES; ph++)
            for (int n = 0; n < RAND_PER_PHASE; n++)
                add_request(pick_value(), pick_value(), ph);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("mamdani_fuzzy_inference_two_input_tb passed");
        end else begin
            $display("mamdani_fuzzy_inference_two_input_tb failed");
        end
        $finish;
    end

endmodule
